[rtl/aste_pkg.sv]
// shared types, constants and helpers of the animation state transition engine
`default_nettype none
package aste_pkg;

  localparam int MAX_STATES_DEF      = 16;
  localparam int MAX_TRANSITIONS_DEF = 16;
  localparam int MAX_CONDITIONS_DEF  = 4;
  localparam int PARAM_COUNT         = 4;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int DIV_STEPS   = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_STATES_IN_USE      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSITIONS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    CMD_WR_STATE = 2'd0,
    CMD_WR_TRANS = 2'd1,
    CMD_WR_COND  = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  localparam logic [2:0] OP_GT   = 3'd0;
  localparam logic [2:0] OP_GE   = 3'd1;
  localparam logic [2:0] OP_LT   = 3'd2;
  localparam logic [2:0] OP_LE   = 3'd3;
  localparam logic [2:0] OP_EQ   = 3'd4;
  localparam logic [2:0] OP_NE   = 3'd5;
  localparam logic [2:0] OP_NONE = 3'd6;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         entry_index;
    logic [1:0]         condition_slot;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
    logic               flag;
  } in_word_t;

  typedef struct packed {
    logic        active;
    logic [3:0]  current_state;
    logic [15:0] current_time;
    logic        blending;
    logic [3:0]  target_state;
    logic [15:0] target_time;
    logic [15:0] blend_tick;
    logic [15:0] blend_duration;
  } out_word_t;

  function automatic logic cond_hold(input logic [2:0] op, input logic signed [31:0] x,
                                     input logic signed [31:0] y);
    logic r;
    case (op)
      OP_GT:   r = x > y;
      OP_GE:   r = x >= y;
      OP_LT:   r = x < y;
      OP_LE:   r = x <= y;
      OP_EQ:   r = x == y;
      OP_NE:   r = x != y;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/aste_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module aste_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/animation_state_transition_engine_core.sv]
// animation state machine with crossfade: tables in rams, tick sequencer and time update
//
//   channel  signals                          direction  word
//   in       in_valid / in_stall / in_data    to block   in_word_t (write or tick)
//   out      out_valid / out_stall / out_data from block out_word_t (one per tick)
//   cfg      cfg_valid / cfg_ready / cfg_index, cfg_data  to block  register write
//
// a tick scans the transitions in use (unless already crossfading), one table entry a
// cycle (a transition row, then its conditions) up to the first match, then runs a clip
// time update (two when crossfading) through the 17-step modulo unit when a loop wraps.
// rst is synchronous and clears control state; the tables hold nothing until written.
// in_stall is high while a tick works; a result waiting in the output register only
// holds back the next tick result, not writes.
`default_nettype none
module animation_state_transition_engine_core #(
  parameter int MAX_STATES      = aste_pkg::MAX_STATES_DEF,
  parameter int MAX_TRANSITIONS = aste_pkg::MAX_TRANSITIONS_DEF,
  parameter int MAX_CONDITIONS  = aste_pkg::MAX_CONDITIONS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire aste_pkg::in_word_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output aste_pkg::out_word_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [aste_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [aste_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int TW    = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int QD    = MAX_TRANSITIONS * MAX_CONDITIONS;
  localparam int QW    = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW    = $clog2(MAX_CONDITIONS + 1);
  localparam int SROW  = 33;
  localparam int TROW  = 4 + 2 * SW + 16 + CW;
  localparam int CROW  = 38;
  localparam int XW    = 9;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SROW = 8'b00000010,
    S_TR   = 8'b00000100,
    S_CD   = 8'b00001000,
    S_OUT  = 8'b00010000,
    S_ADV  = 8'b00100000,
    S_DIV  = 8'b01000000,
    S_FIN  = 8'b10000000
  } fsm_t;

  fsm_t fsm, fsm_next;

  logic [4:0] states_in_use, transitions_in_use;
  logic [4:0] ns, nt;

  logic [TW-1:0] i, i_next;
  logic [QW-1:0] tbase, tbase_next;
  logic [CW-1:0] k, k_next;

  logic signed [31:0] prm [aste_pkg::PARAM_COUNT];
  logic zres;

  logic [SW-1:0] active_state, as_fix;
  logic [15:0]   active_time;
  logic          fade_on;
  logic [SW-1:0] fade_target;
  logic [15:0]   fade_tick, fade_length, fade_time;

  logic signed [15:0] cur_speed, fd_speed;
  logic               cur_loop, fd_loop;
  logic [15:0]        cur_len, fd_len;

  logic [SW-1:0] tr_to_q;
  logic [15:0]   tr_dur_q;
  logic [CW-1:0] tr_cnt_q;

  logic        sel;
  logic [15:0] at_new, ft_new;
  logic [15:0] div_rem;
  logic [16:0] div_dvd;
  logic [4:0]  div_cnt;
  logic        div_neg;

  // ram ports
  logic            st_we, tr_we, cd_we;
  logic [SW-1:0]   st_waddr, st_raddr;
  logic [TW-1:0]   tr_waddr;
  logic [QW-1:0]   cd_waddr, cd_raddr;
  logic [SROW-1:0] st_wdata, st_rdata;
  logic [TROW-1:0] tr_wdata, tr_rdata;
  logic [CROW-1:0] cd_wdata, cd_rdata;

  logic signed [15:0] sr_speed;
  logic               sr_loop;
  logic [15:0]        sr_len;

  logic          tr_from_any, tr_from_ok, tr_to_ok, tr_exit;
  logic [SW-1:0] tr_from, tr_to;
  logic [15:0]   tr_dur;
  logic [CW-1:0] tr_cnt;

  logic               cd_pok;
  logic [1:0]         cd_param;
  logic [2:0]         cd_op;
  logic signed [31:0] cd_value;

  assign {sr_speed, sr_loop, sr_len} = st_rdata;
  assign {tr_from_any, tr_from_ok, tr_from, tr_to_ok, tr_to, tr_dur, tr_exit, tr_cnt} = tr_rdata;
  assign {cd_pok, cd_param, cd_op, cd_value} = cd_rdata;

  logic in_acc, is_tick, out_free;
  assign in_stall  = (fsm != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_tick   = (in_data.command == aste_pkg::CMD_TICK);
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign ns = (XW'(states_in_use) > XW'(MAX_STATES)) ? 5'(MAX_STATES) : states_in_use;
  assign nt = (XW'(transitions_in_use) > XW'(MAX_TRANSITIONS)) ?
              5'(MAX_TRANSITIONS) : transitions_in_use;
  assign as_fix = (XW'(active_state) >= XW'(ns)) ? '0 : active_state;

  // table write words
  always_comb begin
    logic signed [31:0] a, b, c, d;
    logic from_ok, to_ok, pok;
    a = in_data.arg_a;
    b = in_data.arg_b;
    c = in_data.arg_c;
    d = in_data.arg_d;

    st_we = in_acc && in_data.command == aste_pkg::CMD_WR_STATE &&
            XW'(in_data.entry_index) < XW'(MAX_STATES);
    tr_we = in_acc && in_data.command == aste_pkg::CMD_WR_TRANS &&
            XW'(in_data.entry_index) < XW'(MAX_TRANSITIONS);
    cd_we = in_acc && in_data.command == aste_pkg::CMD_WR_COND &&
            XW'(in_data.entry_index) < XW'(MAX_TRANSITIONS) &&
            5'(in_data.condition_slot) < 5'(MAX_CONDITIONS);
    st_waddr = SW'(in_data.entry_index);
    tr_waddr = TW'(in_data.entry_index);
    cd_waddr = QW'(int'(in_data.entry_index) * MAX_CONDITIONS + int'(in_data.condition_slot));

    st_wdata[32:17] = (a > 32'sd32767) ? 16'h7fff : ((a < -32'sd32768) ? 16'h8000 : a[15:0]);
    st_wdata[16]    = in_data.flag;
    st_wdata[15:0]  = (b < 32'sd0) ? 16'h0000 : ((b > 32'sd65535) ? 16'hffff : b[15:0]);

    from_ok = (a >= 32'sd0) && (a < $signed(32'(MAX_STATES)));
    to_ok   = (b >= 32'sd0) && (b < $signed(32'(MAX_STATES)));
    tr_wdata = {a == -32'sd1, from_ok, from_ok ? SW'(a) : SW'(0), to_ok,
                to_ok ? SW'(b) : SW'(0),
                (c <= 32'sd0) ? 16'd1 : ((c > 32'sd65535) ? 16'hffff : c[15:0]),
                in_data.flag,
                (d < 32'sd0) ? CW'(0) :
                ((d > $signed(32'(MAX_CONDITIONS))) ? CW'(MAX_CONDITIONS) : CW'(d))};

    pok = (a >= 32'sd0) && (a < $signed(32'(aste_pkg::PARAM_COUNT)));
    cd_wdata = {pok, pok ? a[1:0] : 2'd0,
                (b >= 32'sd0 && b <= 32'sd5) ? b[2:0] : aste_pkg::OP_NONE, c};
  end

  aste_ram #(.WIDTH(SROW), .DEPTH(MAX_STATES)) u_state_ram (
    .clk(clk), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
    .rd_addr(st_raddr), .rd_data(st_rdata)
  );
  aste_ram #(.WIDTH(TROW), .DEPTH(MAX_TRANSITIONS)) u_trans_ram (
    .clk(clk), .wr_en(tr_we), .wr_addr(tr_waddr), .wr_data(tr_wdata),
    .rd_addr(i_next), .rd_data(tr_rdata)
  );
  aste_ram #(.WIDTH(CROW), .DEPTH(QD)) u_cond_ram (
    .clk(clk), .wr_en(cd_we), .wr_addr(cd_waddr), .wr_data(cd_wdata),
    .rd_addr(cd_raddr), .rd_data(cd_rdata)
  );

  assign st_raddr = (fsm == S_IDLE) ? as_fix : fade_target;
  assign cd_raddr = tbase_next + QW'(k_next);

  // transition checks
  logic pre_ok, cond_ok, more_tr, more_k;
  always_comb begin
    logic to_good, from_good, exit_good;
    to_good   = tr_to_ok && (XW'(tr_to) < XW'(ns)) && (tr_to != active_state);
    from_good = tr_from_any || (tr_from_ok && tr_from == active_state);
    exit_good = !tr_exit || (cur_len != 16'd0 && (17'(active_time) + 17'd1) >= 17'(cur_len));
    pre_ok    = to_good && from_good && exit_good;
    cond_ok   = cd_pok && aste_pkg::cond_hold(cd_op, prm[cd_param], cd_value);
    more_tr   = (XW'(i) + XW'(1)) < XW'(nt);
    more_k    = ((CW+1)'(k) + (CW+1)'(1)) < (CW+1)'(tr_cnt_q);
  end

  // clip time update, shared by current and target
  logic signed [15:0] a_speed;
  logic               a_loop;
  logic [15:0]        a_time, a_len;
  logic signed [17:0] adv_t;
  logic [17:0]        adv_negt;
  logic               adv_under, adv_over, need_div;
  logic [16:0]        adv_mag;
  logic [15:0]        adv_res, rem_next;
  logic               adv_store;
  logic [16:0]        div_sh, div_sub;

  always_comb begin
    a_speed  = sel ? fd_speed : cur_speed;
    a_loop   = sel ? fd_loop : cur_loop;
    a_len    = sel ? fd_len : cur_len;
    a_time   = sel ? fade_time : active_time;
    adv_t    = $signed({2'b00, a_time}) + $signed({{2{a_speed[15]}}, a_speed});
    adv_negt = 18'(-adv_t);
    adv_under = adv_t < 18'sd0;
    adv_over  = adv_t >= $signed({2'b00, a_len});
    adv_mag   = adv_under ? adv_negt[16:0] : adv_t[16:0];
    need_div  = (a_len != 16'd0) && a_loop && (adv_over || adv_under);

    div_sh   = {div_rem, div_dvd[16]};
    div_sub  = div_sh - {1'b0, a_len};
    rem_next = (div_sh >= {1'b0, a_len}) ? div_sub[15:0] : div_sh[15:0];

    if (fsm == S_DIV) begin
      adv_res = div_neg ? ((rem_next == 16'd0) ? 16'd0 : a_len - rem_next) : rem_next;
    end else if (a_len == 16'd0) begin
      adv_res = a_time;
    end else if (adv_over) begin
      adv_res = a_len;
    end else if (adv_under) begin
      adv_res = 16'd0;
    end else begin
      adv_res = adv_t[15:0];
    end
    adv_store = (fsm == S_ADV && !need_div) || (fsm == S_DIV && div_cnt == 5'd1);
  end

  // sequencer
  logic          take_match;
  logic [SW-1:0] match_to;
  logic [15:0]   match_dur;

  always_comb begin
    fsm_next   = fsm;
    i_next     = i;
    tbase_next = tbase;
    k_next     = k;
    take_match = 1'b0;
    match_to   = tr_to_q;
    match_dur  = tr_dur_q;
    unique case (fsm)
      S_IDLE: begin
        i_next     = '0;
        tbase_next = '0;
        k_next     = '0;
        if (in_acc && is_tick) begin
          fsm_next = (ns == 5'd0) ? S_OUT : S_SROW;
        end
      end
      S_SROW: begin
        fsm_next = (fade_on || nt == 5'd0) ? S_OUT : S_TR;
      end
      S_TR: begin
        if (!pre_ok) begin
          if (more_tr) begin
            i_next     = i + TW'(1);
            tbase_next = tbase + QW'(MAX_CONDITIONS);
          end else begin
            fsm_next = S_OUT;
          end
        end else if (tr_cnt == CW'(0)) begin
          take_match = 1'b1;
          match_to   = tr_to;
          match_dur  = tr_dur;
          fsm_next   = S_OUT;
        end else begin
          k_next   = '0;
          fsm_next = S_CD;
        end
      end
      S_CD: begin
        if (!cond_ok) begin
          if (more_tr) begin
            i_next     = i + TW'(1);
            tbase_next = tbase + QW'(MAX_CONDITIONS);
            k_next     = '0;
            fsm_next   = S_TR;
          end else begin
            fsm_next = S_OUT;
          end
        end else if (more_k) begin
          k_next = k + CW'(1);
        end else begin
          take_match = 1'b1;
          fsm_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          fsm_next = zres ? S_IDLE : S_ADV;
        end
      end
      S_ADV, S_DIV: begin
        if (fsm == S_ADV && need_div) begin
          fsm_next = S_DIV;
        end else if (adv_store) begin
          fsm_next = (!sel && fade_on) ? S_ADV : S_FIN;
        end
      end
      S_FIN: begin
        fsm_next = S_IDLE;
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm                <= S_IDLE;
      states_in_use      <= '0;
      transitions_in_use <= '0;
      active_state       <= '0;
      active_time        <= '0;
      fade_on            <= 1'b0;
      fade_target        <= '0;
      fade_tick          <= '0;
      fade_length        <= '0;
      fade_time          <= '0;
      out_valid          <= 1'b0;
      sel                <= 1'b0;
      zres               <= 1'b0;
    end else begin
      fsm   <= fsm_next;
      i     <= i_next;
      tbase <= tbase_next;
      k     <= k_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aste_pkg::REG_STATES_IN_USE:      states_in_use <= cfg_data;
          aste_pkg::REG_TRANSITIONS_IN_USE: transitions_in_use <= cfg_data;
          default: ;
        endcase
      end

      if (fsm == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (fsm)
        S_IDLE: begin
          if (in_acc && is_tick) begin
            prm[0] <= in_data.arg_a;
            prm[1] <= in_data.arg_b;
            prm[2] <= in_data.arg_c;
            prm[3] <= in_data.arg_d;
            zres   <= (ns == 5'd0);
            sel    <= 1'b0;
            if (ns != 5'd0) begin
              active_state <= as_fix;
            end
          end
        end
        S_SROW: begin
          cur_speed <= sr_speed;
          cur_loop  <= sr_loop;
          cur_len   <= sr_len;
        end
        S_TR, S_CD: begin
          if (fsm == S_TR) begin
            tr_to_q  <= tr_to;
            tr_dur_q <= tr_dur;
            tr_cnt_q <= tr_cnt;
          end
          if (take_match) begin
            fade_on     <= 1'b1;
            fade_target <= match_to;
            fade_tick   <= '0;
            fade_length <= match_dur;
            fade_time   <= '0;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (zres) begin
              out_data <= '0;
            end else begin
              out_data.active         <= 1'b1;
              out_data.current_state  <= 4'(active_state);
              out_data.current_time   <= active_time;
              out_data.blending       <= fade_on;
              out_data.target_state   <= fade_on ? 4'(fade_target) : 4'd0;
              out_data.target_time    <= fade_on ? fade_time : 16'd0;
              out_data.blend_tick     <= fade_on ? fade_tick : 16'd0;
              out_data.blend_duration <= fade_on ? fade_length : 16'd0;
            end
          end
        end
        S_ADV, S_DIV: begin
          // target row read is settled by now
          if (fsm == S_ADV && !sel) begin
            fd_speed <= sr_speed;
            fd_loop  <= sr_loop;
            fd_len   <= sr_len;
          end
          if (fsm == S_ADV && need_div) begin
            div_dvd <= adv_mag;
            div_rem <= '0;
            div_cnt <= 5'(aste_pkg::DIV_STEPS);
            div_neg <= adv_under;
          end
          if (fsm == S_DIV) begin
            div_rem <= rem_next;
            div_dvd <= {div_dvd[15:0], 1'b0};
            div_cnt <= div_cnt - 5'd1;
          end
          if (adv_store) begin
            if (!sel) begin
              at_new <= adv_res;
              if (fade_on) begin
                sel <= 1'b1;
              end
            end else begin
              ft_new <= adv_res;
            end
          end
        end
        S_FIN: begin
          if (fade_on && (17'(fade_tick) + 17'd1) >= 17'(fade_length)) begin
            active_state <= fade_target;
            active_time  <= ft_new;
            fade_on      <= 1'b0;
            fade_target  <= '0;
            fade_tick    <= '0;
            fade_length  <= '0;
            fade_time    <= '0;
          end else begin
            active_time <= at_new;
            if (fade_on) begin
              fade_time <= ft_new;
              fade_tick <= fade_tick + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[test/aste_scoreboard.sv]
// pose and crossfade predictor with result comparison for the state transition engine
module aste_scoreboard (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire aste_pkg::in_word_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire aste_pkg::out_word_t out_data,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [aste_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [aste_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                       pending,
  output int                       errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import aste_pkg::*;

  int n_states, n_trans;
  int spd [16];
  bit lp [16];
  int clip [16];
  bit tr_any [16];
  bit tr_from_ok [16];
  int tr_from [16];
  bit tr_to_ok [16];
  int tr_to [16];
  int tr_dur [16];
  bit tr_exit [16];
  int tr_cnt [16];
  bit cd_par_ok [64];
  int cd_par [64];
  int cd_op [64];
  int cd_val [64];
  int cur_state, cur_time, fade_to, fade_tick, fade_len, fade_time;
  bit fading;
  out_word_t pose_due [$];

  function automatic int step_time(int t, int st);
    int len;
    int n;
    len = clip[st];
    if (len <= 0) return t;
    n = t + spd[st];
    if (n >= len) n = lp[st] ? n % len : len;
    else if (n < 0) n = lp[st] ? ((n % len) + len) % len : 0;
    return n;
  endfunction

  function automatic bit holds(int op, int x, int y);
    case (op)
      OP_GT:   return x > y;
      OP_GE:   return x >= y;
      OP_LT:   return x < y;
      OP_LE:   return x <= y;
      OP_EQ:   return x == y;
      OP_NE:   return x != y;
      default: return 1'b0;
    endcase
  endfunction

  task automatic apply_word(in_word_t w);
    int a, b, c, d, ns, nt, p[4], len;
    bit ok;
    out_word_t r;
    a = w.arg_a; b = w.arg_b; c = w.arg_c; d = w.arg_d;
    case (cmd_t'(w.command))
      CMD_WR_STATE: begin
        spd[w.entry_index] = a > 32767 ? 32767 : (a < -32768 ? -32768 : a);
        lp[w.entry_index] = w.flag;
        clip[w.entry_index] = b < 0 ? 0 : (b > 65535 ? 65535 : b);
      end
      CMD_WR_TRANS: begin
        tr_any[w.entry_index] = a == -1;
        tr_from_ok[w.entry_index] = a >= 0 && a < 16;
        tr_from[w.entry_index] = a;
        tr_to_ok[w.entry_index] = b >= 0 && b < 16;
        tr_to[w.entry_index] = b;
        tr_dur[w.entry_index] = c <= 0 ? 1 : (c > 65535 ? 65535 : c);
        tr_exit[w.entry_index] = w.flag;
        tr_cnt[w.entry_index] = d < 0 ? 0 : (d > 4 ? 4 : d);
      end
      CMD_WR_COND: begin
        cd_par_ok[w.entry_index*4 + w.condition_slot] = a >= 0 && a < PARAM_COUNT;
        cd_par[w.entry_index*4 + w.condition_slot] = a;
        cd_op[w.entry_index*4 + w.condition_slot] = (b >= 0 && b <= 5) ? b : int'(OP_NONE);
        cd_val[w.entry_index*4 + w.condition_slot] = c;
      end
      default: begin
        r = '0;
        ns = n_states > 16 ? 16 : n_states;
        nt = n_trans > 16 ? 16 : n_trans;
        if (ns != 0) begin
          p[0] = a; p[1] = b; p[2] = c; p[3] = d;
          if (cur_state >= ns) cur_state = 0;
          if (!fading) begin
            for (int i = 0; i < nt; i++) begin
              if (!tr_to_ok[i] || tr_to[i] >= ns || tr_to[i] == cur_state) continue;
              if (!tr_any[i] && !(tr_from_ok[i] && tr_from[i] == cur_state)) continue;
              if (tr_exit[i]) begin
                len = clip[cur_state];
                if (!(len > 0 && cur_time + 1 >= len)) continue;
              end
              ok = 1'b1;
              for (int k = 0; k < tr_cnt[i] && ok; k++)
                if (!cd_par_ok[i*4+k] || !holds(cd_op[i*4+k], p[cd_par[i*4+k]], cd_val[i*4+k]))
                  ok = 1'b0;
              if (!ok) continue;
              fading = 1'b1;
              fade_to = tr_to[i];
              fade_tick = 0;
              fade_len = tr_dur[i];
              fade_time = 0;
              break;
            end
          end
          r.active = 1'b1;
          r.current_state = cur_state[3:0];
          r.current_time = cur_time[15:0];
          if (fading) begin
            r.blending = 1'b1;
            r.target_state = fade_to[3:0];
            r.target_time = fade_time[15:0];
            r.blend_tick = fade_tick[15:0];
            r.blend_duration = fade_len[15:0];
          end
          cur_time = step_time(cur_time, cur_state);
          if (fading) begin
            fade_time = step_time(fade_time, fade_to);
            fade_tick++;
            if (fade_tick >= fade_len) begin
              cur_state = fade_to;
              cur_time = fade_time;
              fading = 1'b0;
              fade_to = 0; fade_tick = 0; fade_len = 0; fade_time = 0;
            end
          end
        end
        pose_due = {pose_due, r};
      end
    endcase
  endtask

  function automatic int field_bad(string name, logic [15:0] e, logic [15:0] g);
    if (e === g) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, e, g);
    return 1;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    int bad;
    if (rst) begin
      n_states = 0; n_trans = 0;
      cur_state = 0; cur_time = 0; fading = 1'b0;
      fade_to = 0; fade_tick = 0; fade_len = 0; fade_time = 0;
      pose_due.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STATES_IN_USE) n_states = cfg_data;
        else n_trans = cfg_data;
      end
      if (in_valid && !in_stall) apply_word(in_data);
      if (out_valid && !out_stall) begin
        if (pose_due.size() == 0) begin
          $display("%0t: unexpected result word %h, expected none", $time, out_data);
          errors++;
        end else begin
          e = pose_due.pop_front();
          bad = field_bad("active", e.active, out_data.active)
              + field_bad("current_state", e.current_state, out_data.current_state)
              + field_bad("current_time", e.current_time, out_data.current_time)
              + field_bad("blending", e.blending, out_data.blending)
              + field_bad("target_state", e.target_state, out_data.target_state)
              + field_bad("target_time", e.target_time, out_data.target_time)
              + field_bad("blend_tick", e.blend_tick, out_data.blend_tick)
              + field_bad("blend_duration", e.blend_duration, out_data.blend_duration);
          if (bad != 0) errors++;
        end
      end
    end
    pending = pose_due.size();
  end
endmodule

[test/tb_top.sv]
// stimulus and verdict for the animation state transition engine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aste_pkg::*;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int pending, errors;
  bit calm;

  animation_state_transition_engine_core u_top (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  aste_scoreboard u_sb (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .errors
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int gap_draw();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // mostly a narrow window so conditions and clip ends get hit, now and then any value
  function automatic int pick(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send(cmd_t cmd, int idx, int slot, int a, int b, int c, int d, bit f);
    int g;
    g = gap_draw();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{command: cmd, entry_index: idx[3:0], condition_slot: slot[1:0],
                 arg_a: a, arg_b: b, arg_c: c, arg_d: d, flag: f};
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, int v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_DATA_W-1:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    case ($urandom_range(0, 9))
      0: send(CMD_WR_STATE, $urandom, $urandom, pick(-4, 6), pick(-2, 12), $urandom,
              $urandom, 1'($urandom));
      1: send(CMD_WR_TRANS, $urandom, $urandom, pick(-2, 16), pick(-1, 16), pick(-1, 5),
              pick(-1, 5), 1'($urandom));
      2: send(CMD_WR_COND, $urandom, $urandom, pick(-1, 4), pick(-1, 6), pick(-3, 3),
              $urandom, 1'($urandom));
      default: send(CMD_TICK, $urandom, $urandom, pick(-3, 3), pick(-3, 3), pick(-3, 3),
                    pick(-3, 3), 1'($urandom));
    endcase
  endtask

  initial begin
    int settings [5];
    settings = '{0, 1, 16, 31, 5};
    rst = 1'b1;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every table entry so no tick ever reads an unwritten one
    for (int i = 0; i < 16; i++) begin
      send(CMD_WR_STATE, i, 0, pick(-4, 6), pick(0, 12), 0, 0, 1'($urandom));
      send(CMD_WR_TRANS, i, 0, pick(-1, 16), pick(-1, 16), pick(-1, 5), pick(-1, 5),
           1'($urandom));
      for (int s = 0; s < 4; s++)
        send(CMD_WR_COND, i, s, pick(-1, 4), pick(-1, 6), pick(-3, 3), 0, 0);
    end

    // no states: every result field zero
    send(CMD_TICK, 0, 0, 32'h7fffffff, 32'h80000000, -1, 0, 1'b0);
    set_reg(REG_STATES_IN_USE, 16);
    set_reg(REG_TRANSITIONS_IN_USE, 16);

    // saturating speed, clip length and duration extremes
    send(CMD_WR_STATE, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0, 1'b1);
    send(CMD_WR_STATE, 1, 0, 32'h80000000, 32'h80000000, 0, 0, 1'b0);
    send(CMD_WR_STATE, 2, 0, -3, 5, 0, 0, 1'b1);
    send(CMD_WR_TRANS, 0, 0, -1, 2, 0, -7, 1'b0);
    send(CMD_WR_TRANS, 1, 0, 99, -3, 32'h7fffffff, 99, 1'b1);
    send(CMD_WR_TRANS, 2, 0, 2, 1, -5, 4, 1'b1);
    send(CMD_WR_TRANS, 3, 0, 1, 0, 32'h80000000, 4, 1'b0);
    // every compare op, a bad op and a bad parameter index
    for (int s = 0; s < 4; s++)
      send(CMD_WR_COND, 2, s, s, s, 0, 0, 1'b0);
    send(CMD_WR_COND, 3, 0, 0, int'(OP_EQ), 1, 0, 1'b0);
    send(CMD_WR_COND, 3, 1, 1, int'(OP_NE), 1, 0, 1'b0);
    send(CMD_WR_COND, 3, 2, 7, int'(OP_GT), 0, 0, 1'b0);
    send(CMD_WR_COND, 3, 3, 2, 9, 0, 0, 1'b0);
    for (int i = 0; i < 6; i++)
      send(CMD_TICK, 0, 0, i - 3, 1, -1, 0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      calm = ph % 3 == 1;
      set_reg(REG_STATES_IN_USE, ph == 0 ? 16 : settings[$urandom_range(0, 4)]);
      set_reg(REG_TRANSITIONS_IN_USE, ph == 0 ? 16 : settings[$urandom_range(0, 4)]);
      for (int n = 0; n < 200; n++) random_word();
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // result side stall, drawn per word
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = gap_draw();
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end
endmodule

[filelist.f]
rtl/aste_pkg.sv
rtl/aste_ram.sv
rtl/animation_state_transition_engine_core.sv
test/aste_scoreboard.sv
test/tb_top.sv
